// ===== design/hcb_pkg.sv =====
package hcb_pkg;

  // node index width covers the largest tree (2*32-1 nodes) plus the no-parent code
  localparam int unsigned NODE_W = 6;
  localparam logic [NODE_W-1:0] NO_PARENT = '1;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned CODE_W = 31;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [15:0] weight;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [4:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              final_res;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_MERGE1,
    OP_MERGE2,
    OP_MERGE3,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_CHK,
    OP_EMIT
  } hcb_op_e;

  typedef struct packed {
    hcb_op_e           op;
    logic [NODE_W-1:0] idx;
    logic [NODE_W-1:0] top;
    logic              final_leaf;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

// ===== design/hcb_ram.sv =====
module hcb_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i[IDX_W-1:0]] <= wdata_i;
    end
    rdata_o <= mem[raddr_i[IDX_W-1:0]];
  end
endmodule

// ===== design/hcb_datapath.sv =====
module hcb_datapath #(
  parameter int unsigned LEAVES      = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     weight_i,
  input  hcb_pkg::cmd_t   cmd_i,
  output hcb_pkg::status_t status_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output hcb_pkg::out_t   out_data_o
);
  import hcb_pkg::*;

  localparam int unsigned NODES = 2 * LEAVES - 1;
  localparam int unsigned WW    = WEIGHT_BITS + $clog2(LEAVES) + 1;
  localparam int unsigned PW    = NODE_W + 1;

  logic [31:0]       w_ext;
  logic [WW-1:0]     w_in;
  logic              wr_we;
  logic [NODE_W-1:0] wr_addr;
  logic [WW-1:0]     wr_data;
  logic              pr_we;
  logic [NODE_W-1:0] pr_addr;
  logic [PW-1:0]     pr_data;
  logic [NODE_W-1:0] rd_addr;
  logic [WW-1:0]     w_rd;
  logic [PW-1:0]     p_rd;
  logic [NODE_W-1:0] par_rd;
  logic              right_rd;

  // scan state
  logic              rv_q;
  logic [NODE_W-1:0] ridx_q;
  logic [WW-1:0]     w1_q, w2_q;
  logic [NODE_W-1:0] x1_q, x2_q;
  logic              f1_q, f2_q;

  // walk state
  logic [NODE_W-1:0] c_q;
  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  len_q;

  logic              out_valid_q;
  out_t              out_q;

  assign w_ext    = {16'd0, weight_i};
  assign w_in     = WW'(w_ext[WEIGHT_BITS-1:0]);
  assign par_rd   = p_rd[NODE_W-1:0];
  assign right_rd = p_rd[PW-1];

  always_comb begin
    wr_we   = 1'b0;
    wr_addr = cmd_i.top;
    wr_data = w1_q + w2_q;
    pr_we   = 1'b0;
    pr_addr = cmd_i.top;
    pr_data = {1'b0, NO_PARENT};
    unique case (cmd_i.op)
      OP_LOAD: begin
        wr_we   = 1'b1;
        wr_addr = cmd_i.idx;
        wr_data = w_in;
        pr_we   = 1'b1;
        pr_addr = cmd_i.idx;
      end
      OP_MERGE1: begin
        wr_we   = 1'b1;
        pr_we   = 1'b1;
        pr_addr = x1_q;
        pr_data = {1'b0, cmd_i.top};
      end
      OP_MERGE2: begin
        pr_we   = 1'b1;
        pr_addr = x2_q;
        pr_data = {1'b1, cmd_i.top};
      end
      OP_MERGE3: begin
        pr_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_addr = (cmd_i.op == OP_SCAN) ? cmd_i.idx : c_q;

  hcb_ram #(.WIDTH(WW), .DEPTH(NODES), .ADDR_W(NODE_W)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wr_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (w_rd)
  );

  hcb_ram #(.WIDTH(PW), .DEPTH(NODES), .ADDR_W(NODE_W)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pr_addr),
    .wdata_i (pr_data),
    .raddr_i (rd_addr),
    .rdata_o (p_rd)
  );

  // two-smallest search, strict less-than keeps the earlier index on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end else begin
      rv_q <= (cmd_i.op == OP_SCAN);
      if (cmd_i.op == OP_SCAN && cmd_i.idx == '0) begin
        f1_q <= 1'b0;
        f2_q <= 1'b0;
      end else if (rv_q && par_rd == NO_PARENT) begin
        if (!f1_q || w_rd < w1_q) begin
          f2_q <= f1_q;
          f1_q <= 1'b1;
        end else if (!f2_q || w_rd < w2_q) begin
          f2_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cmd_i.idx;
    if (rv_q && par_rd == NO_PARENT) begin
      if (!f1_q || w_rd < w1_q) begin
        w2_q <= w1_q;
        x2_q <= x1_q;
        w1_q <= w_rd;
        x1_q <= ridx_q;
      end else if (!f2_q || w_rd < w2_q) begin
        w2_q <= w_rd;
        x2_q <= ridx_q;
      end
    end
  end

  assign status_o.walk_done = (par_rd == NO_PARENT) || (len_q == LEN_MAX);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WALK_INIT) begin
      c_q    <= cmd_i.idx;
      code_q <= '0;
      len_q  <= '0;
    end else if (cmd_i.op == OP_WALK_CHK && !status_o.walk_done) begin
      code_q <= code_q | (CODE_W'(right_rd) << len_q);
      len_q  <= len_q + 1'b1;
      c_q    <= par_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_q.symbol      <= cmd_i.idx[4:0];
      out_q.code_bits   <= code_q;
      out_q.code_length <= len_q;
      out_q.final_res   <= cmd_i.final_leaf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== design/hcb_ctrl.sv =====
module hcb_ctrl #(
  parameter int unsigned LEAVES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  input  hcb_pkg::status_t status_i,
  output hcb_pkg::cmd_t    cmd_o
);
  import hcb_pkg::*;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SCAN_END = 4'd2;
  localparam logic [3:0] S_MERGE1   = 4'd3;
  localparam logic [3:0] S_MERGE2   = 4'd4;
  localparam logic [3:0] S_MERGE3   = 4'd5;
  localparam logic [3:0] S_WINIT    = 4'd6;
  localparam logic [3:0] S_WRD      = 4'd7;
  localparam logic [3:0] S_WCHK     = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  localparam logic [NODE_W-1:0] LEAVES_N = NODE_W'(LEAVES);

  logic [3:0]        state_q, state_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  logic [NODE_W-1:0] n_q, n_d;
  logic [NODE_W-1:0] top_q, top_d;
  logic [NODE_W-1:0] j_q, j_d;
  logic [NODE_W-1:0] leaf_q, leaf_d;
  logic              room;
  logic [NODE_W-1:0] n_new;
  logic [NODE_W:0]   top_next;
  logic [NODE_W:0]   top_end;
  logic              final_leaf;

  assign room       = (cnt_q < LEAVES_N);
  assign n_new      = cnt_q + NODE_W'(room);
  assign top_next   = {1'b0, top_q} + 1'b1;
  assign top_end    = {n_q, 1'b0} - 1'b1;
  assign final_leaf = (leaf_q == n_q - 1'b1);
  assign in_stall_o = (state_q != S_LOAD);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    top_d   = top_q;
    j_d     = j_q;
    leaf_d  = leaf_q;
    cmd_o.op         = OP_NONE;
    cmd_o.idx        = j_q;
    cmd_o.top        = top_q;
    cmd_o.final_leaf = final_leaf;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.idx = cnt_q;
        if (in_valid_i) begin
          if (room) begin
            cmd_o.op = OP_LOAD;
            cnt_d    = cnt_q + 1'b1;
          end
          if (in_last_i) begin
            cnt_d  = '0;
            n_d    = n_new;
            top_d  = n_new;
            j_d    = '0;
            leaf_d = '0;
            state_d = (n_new == NODE_W'(1)) ? S_WINIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (j_q == top_q - 1'b1) begin
          state_d = S_SCAN_END;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SCAN_END: state_d = S_MERGE1;
      S_MERGE1: begin
        cmd_o.op = OP_MERGE1;
        state_d  = S_MERGE2;
      end
      S_MERGE2: begin
        cmd_o.op = OP_MERGE2;
        state_d  = S_MERGE3;
      end
      S_MERGE3: begin
        cmd_o.op = OP_MERGE3;
        top_d    = top_next[NODE_W-1:0];
        j_d      = '0;
        state_d  = (top_next == top_end) ? S_WINIT : S_SCAN;
      end
      S_WINIT: begin
        cmd_o.op  = OP_WALK_INIT;
        cmd_o.idx = leaf_q;
        state_d   = S_WRD;
      end
      S_WRD: begin
        cmd_o.op = OP_WALK_RD;
        state_d  = S_WCHK;
      end
      S_WCHK: begin
        cmd_o.op = OP_WALK_CHK;
        state_d  = status_i.walk_done ? S_EMIT : S_WRD;
      end
      S_EMIT: begin
        cmd_o.idx = leaf_q;
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (final_leaf) begin
            state_d = S_LOAD;
          end else begin
            leaf_d  = leaf_q + 1'b1;
            state_d = S_WINIT;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      n_q     <= '0;
      top_q   <= '0;
      j_q     <= '0;
      leaf_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      top_q   <= top_d;
      j_q     <= j_d;
      leaf_q  <= leaf_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LEAVES_N)
    else $error("symbol count beyond leaf capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_EMIT |-> status_i.out_free)
    else $error("result loaded over a waiting result");

  a_merge_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MERGE1 |=> state_q == S_MERGE2 ##1 state_q == S_MERGE3)
    else $error("merge write sequence broken");

  a_leaf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> leaf_q < n_q)
    else $error("leaf index past symbol set");
endmodule

// ===== design/huffman_code_builder_top.sv =====
// huffman code builder
// input channel: one beat per symbol weight (low WEIGHT_BITS bits used), in
// load order; the beat with last set closes the set and starts the build.
// beats beyond LEAVES symbols are dropped, a last beat still starts the build
// output channel: one beat per symbol, in load order, carrying the symbol index,
// the root-first code right-aligned (0 = left child) and its length; final_res
// marks the beat of the last symbol. a single symbol gets an empty code
// loading takes one beat per cycle. for n symbols the build makes n-1
// merges, merge k scanning all n+k nodes held so far through the node memory
// read port at one node a cycle, then writing the new node and both child links
// each code is then found by walking the parent links one level at a time,
// with a read and a check per level, before its beat goes out
// in_stall_o is high from the last beat until the last code is in the output
// register; the output register lets the next set start loading while the
// final code still waits. a stalled output holds the emission of the next code
// reset: empty symbol set, no result pending, loading; node memories need no
// clearing since every node is written before it is read
module huffman_code_builder_top #(
  parameter int unsigned LEAVES      = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hcb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hcb_pkg::out_t out_data_o
);
  import hcb_pkg::*;

  // command/status link between the sequencer and the tree datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: load count, merge and scan counters, code walk per leaf
  hcb_ctrl #(.LEAVES(LEAVES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // node memories, two-smallest search, code walk registers, output register
  hcb_datapath #(.LEAVES(LEAVES), .WEIGHT_BITS(WEIGHT_BITS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weight_i    (in_data_i.weight),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
